@@ design/aspw_pkg.sv @@
package aspw_pkg;

  localparam int LEVEL_W  = 16;
  localparam int VOLUME_W = 7;
  localparam int PERIOD_W = 20;
  localparam int CFG_IDX_W = 2;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic [7:0] low_byte;
    logic [7:0] high_byte;
  } in_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] high_time;
    logic [LEVEL_W-1:0]  smoothed_level;
  } out_item_t;

  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  localparam logic [VOLUME_W-1:0] VOLUME_RESET = 7'd50;
  localparam logic                WIDE_RESET   = 1'b1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd250000;

  localparam level_t     LEVEL_MID  = 16'h8000;
  localparam logic [7:0] SIGN_FLIP  = 8'h80;

  localparam logic [6:0]  PCT_FULL       = 7'd100;
  localparam logic [15:0] RECIP_100      = 16'd41943;
  localparam int          RECIP_100_SHIFT = 22;

  localparam logic [2:0]  WEIGHT_FIFTH   = 3'd5;
  localparam logic [17:0] RECIP_5        = 18'd209715;
  localparam int          RECIP_5_SHIFT  = 20;

  localparam logic [3:0]  TENTHS         = 4'd10;
  localparam logic [23:0] RECIP_10       = 24'd13421772;
  localparam int          RECIP_10_SHIFT = 27;

  localparam logic [15:0] LEVEL_FULL = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

endpackage

@@ design/aspw_front.sv @@
module aspw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aspw_pkg::in_item_t in_data,
  input  logic               wide_samples,
  input  logic               queue_full,
  output logic               push_valid,
  output aspw_pkg::level_t   push_level
);

  logic             hold_valid;
  aspw_pkg::level_t hold_level;
  aspw_pkg::level_t level;
  logic             accept;

  always_comb begin
    if (wide_samples) begin
      level = {in_data.high_byte ^ aspw_pkg::SIGN_FLIP, in_data.low_byte};
    end else begin
      level = {in_data.low_byte, 8'h00};
    end
  end

  assign in_stall   = hold_valid && queue_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = hold_valid;
  assign push_level = hold_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && !queue_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_level <= level;
    end
  end

endmodule

@@ design/aspw_queue.sv @@
module aspw_queue #(
  parameter int DEPTH = aspw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  aspw_pkg::level_t push_level,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output aspw_pkg::level_t pop_level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  aspw_pkg::level_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && !empty;
  assign pop_level = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_level;
    end
  end

endmodule

@@ design/aspw_back.sv @@
module aspw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [6:0]            volume_percent,
  input  logic [19:0]           pwm_period,
  input  logic                  queue_empty,
  input  aspw_pkg::level_t      queue_level,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aspw_pkg::out_item_t   out_data
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_SCALE  = 8'b00000010,
    ST_DIV100 = 8'b00000100,
    ST_FIX100 = 8'b00001000,
    ST_DIV5   = 8'b00010000,
    ST_FIX5   = 8'b00100000,
    ST_SPAN   = 8'b01000000,
    ST_WRAP   = 8'b10000000
  } state_t;

  state_t           state;
  state_t           state_next;
  aspw_pkg::level_t previous_level;
  aspw_pkg::level_t level;
  logic [22:0]      vprod;
  logic [16:0]      q100;
  logic [18:0]      mix;
  logic [15:0]      q5;
  aspw_pkg::level_t smooth;
  logic [23:0]      p9;
  logic [19:0]      plo_est;
  logic [19:0]      plo;
  logic [19:0]      phi_est;
  logic [19:0]      phi;
  logic [19:0]      span;
  logic [35:0]      sprod;

  logic [38:0]      div100_prod;
  logic [23:0]      r100;
  logic [16:0]      scaled_wide;
  aspw_pkg::level_t scaled;
  logic [37:0]      div5_prod;
  logic [18:0]      r5;
  aspw_pkg::level_t smooth_now;
  logic [47:0]      plo_prod;
  logic [47:0]      phi_prod;
  logic [20:0]      rlo;
  logic [24:0]      rhi;
  logic [19:0]      fold_q0;
  logic [20:0]      fold_r1;
  logic [4:0]       fold_q1;
  logic [16:0]      fold_r2;
  logic [19:0]      fold_q;
  logic             out_free;

  assign pop      = (state == ST_IDLE) && !queue_empty;
  assign out_free = !out_valid || !out_stall;

  assign div100_prod = 39'(vprod) * 39'(aspw_pkg::RECIP_100);
  assign r100        = 24'(vprod) - 24'(q100) * 24'(aspw_pkg::PCT_FULL);
  assign scaled_wide = q100 + 17'(r100 >= 24'(aspw_pkg::PCT_FULL));
  assign scaled      = scaled_wide[16] ? aspw_pkg::LEVEL_FULL : scaled_wide[15:0];

  assign div5_prod  = 38'(mix) * 38'(aspw_pkg::RECIP_5);
  assign r5         = mix - 19'(q5) * 19'(aspw_pkg::WEIGHT_FIFTH);
  assign smooth_now = q5 + 16'(r5 >= 19'(aspw_pkg::WEIGHT_FIFTH));

  assign plo_prod = 48'(pwm_period) * 48'(aspw_pkg::RECIP_10);
  assign phi_prod = 48'(p9) * 48'(aspw_pkg::RECIP_10);
  assign rlo      = 21'(pwm_period) - 21'(plo_est) * 21'(aspw_pkg::TENTHS);
  assign rhi      = 25'(p9) - 25'(phi_est) * 25'(aspw_pkg::TENTHS);

  // Division by 65535 through two folds of the upper half onto the lower half.
  assign fold_q0 = sprod[35:16];
  assign fold_r1 = 21'(sprod[15:0]) + 21'(fold_q0);
  assign fold_q1 = fold_r1[20:16];
  assign fold_r2 = 17'(fold_r1[15:0]) + 17'(fold_q1);
  assign fold_q  = fold_q0 + 20'(fold_q1) + 20'(fold_r2 >= 17'(aspw_pkg::LEVEL_FULL));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!queue_empty) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:  state_next = ST_DIV100;
      ST_DIV100: state_next = ST_FIX100;
      ST_FIX100: state_next = ST_DIV5;
      ST_DIV5:   state_next = ST_FIX5;
      ST_FIX5:   state_next = ST_SPAN;
      ST_SPAN:   state_next = ST_WRAP;
      ST_WRAP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      previous_level <= aspw_pkg::LEVEL_MID;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIX5) begin
        previous_level <= smooth_now;
      end
      if (state == ST_WRAP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      level <= queue_level;
    end
    if (state == ST_SCALE) begin
      vprod <= 23'(level) * 23'(volume_percent);
      p9    <= {1'b0, pwm_period, 3'b000} + 24'(pwm_period);
    end
    if (state == ST_DIV100) begin
      q100    <= 17'(div100_prod >> aspw_pkg::RECIP_100_SHIFT);
      plo_est <= 20'(plo_prod >> aspw_pkg::RECIP_10_SHIFT);
    end
    if (state == ST_FIX100) begin
      mix     <= 19'({scaled, 2'b00}) + 19'(previous_level);
      plo     <= plo_est + 20'(rlo >= 21'(aspw_pkg::TENTHS));
      phi_est <= 20'(phi_prod >> aspw_pkg::RECIP_10_SHIFT);
    end
    if (state == ST_DIV5) begin
      q5  <= 16'(div5_prod >> aspw_pkg::RECIP_5_SHIFT);
      phi <= phi_est + 20'(rhi >= 25'(aspw_pkg::TENTHS));
    end
    if (state == ST_FIX5) begin
      smooth <= smooth_now;
      span   <= phi - plo;
    end
    if (state == ST_SPAN) begin
      sprod <= 36'(smooth) * 36'(span);
    end
    if (state == ST_WRAP && out_free) begin
      out_data.high_time      <= plo + fold_q;
      out_data.smoothed_level <= smooth;
    end
  end

endmodule

@@ design/audio_sample_to_pwm_width.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_data  (low_byte, high_byte)
// output    out_valid / out_stall  out_data (high_time, smoothed_level)
// config    cfg_write              cfg_index, cfg_data
//
// The back-end sequencer handles one sample at a time, from ST_IDLE through ST_WRAP, which is the limit on throughput.
// A sample passes the front holding register, the queue and the back-end sequencer on its way to the output register.
// Reset is synchronous; it restores the register defaults and a previous level of 32768.
// Input stalls only when the front stage holds a sample and the queue is full.
// A result held by out_stall keeps the sequencer waiting at its last step.
module audio_sample_to_pwm_width #(
  parameter int QUEUE_DEPTH = aspw_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aspw_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aspw_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [aspw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aspw_pkg::PERIOD_W-1:0]       cfg_data
);

  logic [aspw_pkg::VOLUME_W-1:0] volume_percent;
  logic                          wide_samples;
  logic [aspw_pkg::PERIOD_W-1:0] pwm_period;

  logic             push_valid;
  aspw_pkg::level_t push_level;
  logic             queue_full;
  logic             queue_empty;
  logic             pop;
  aspw_pkg::level_t queue_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_percent <= aspw_pkg::VOLUME_RESET;
      wide_samples   <= aspw_pkg::WIDE_RESET;
      pwm_period     <= aspw_pkg::PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        aspw_pkg::REG_VOLUME: volume_percent <= cfg_data[aspw_pkg::VOLUME_W-1:0];
        aspw_pkg::REG_WIDE:   wide_samples   <= cfg_data[0];
        aspw_pkg::REG_PERIOD: pwm_period     <= cfg_data;
        default: ;
      endcase
    end
  end

  aspw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .wide_samples (wide_samples),
    .queue_full   (queue_full),
    .push_valid   (push_valid),
    .push_level   (push_level)
  );

  aspw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_level (push_level),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .pop_level  (queue_level)
  );

  aspw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .volume_percent (volume_percent),
    .pwm_period     (pwm_period),
    .queue_empty    (queue_empty),
    .queue_level    (queue_level),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
